@@ sv/duplicate_request_reply_cache_assert.svh @@
// Assertion macros for the duplicate request reply cache.
`ifndef DUPLICATE_REQUEST_REPLY_CACHE_ASSERT_SVH
`define DUPLICATE_REQUEST_REPLY_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DRRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("drrc assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DRRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("drrc assertion failed");

`endif

@@ sv/drrc_pkg.sv @@
// Types and constants shared by the duplicate request reply cache.
package drrc_pkg;

  localparam int unsigned SLOTS        = 64;
  localparam int unsigned SLOT_IDX_W   = $clog2(SLOTS);
  localparam int unsigned SLOT_FIELD_W = 6;
  localparam int unsigned WORD_W       = 32;

  typedef enum logic [1:0] {
    ACT_DROP_BAD   = 2'd0,
    ACT_REPLAY     = 2'd1,
    ACT_DROP_STALE = 2'd2,
    ACT_EXECUTE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic              frame_ok;
    logic [WORD_W-1:0] magic_word;
    logic [WORD_W-1:0] caller_id;
    logic [WORD_W-1:0] seq_number;
  } req_t;

  typedef struct packed {
    action_e                 action;
    logic [SLOT_FIELD_W-1:0] slot_index;
    logic [WORD_W-1:0]       handled_count;
    logic [WORD_W-1:0]       duplicate_count;
  } rsp_t;

  typedef struct packed {
    logic [WORD_W-1:0] client;
    logic [WORD_W-1:0] seq;
  } entry_t;

  typedef struct packed {
    logic                  done;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic [WORD_W-1:0]     hit_seq;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
  } scan_res_t;

endpackage

@@ sv/drrc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module drrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ sv/drrc_scan.sv @@
// Slot table scanner: walks all slots, finds the client and the lowest free slot.
module drrc_scan import drrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WORD_W-1:0]     caller_id_i,
  input  logic [SLOTS-1:0]      valid_i,
  input  entry_t                rdata_i,
  output logic                  re_o,
  output logic [SLOT_IDX_W-1:0] raddr_o,
  output scan_res_t             res_o
);

  logic                  busy_q, busy_d;
  logic [SLOT_IDX_W-1:0] addr_q, addr_d;
  logic                  chk_q;
  logic [SLOT_IDX_W-1:0] chk_idx_q;
  logic                  hit_q, hit_d;
  logic [SLOT_IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [WORD_W-1:0]     hit_seq_q, hit_seq_d;
  logic                  free_q, free_d;
  logic [SLOT_IDX_W-1:0] free_idx_q, free_idx_d;
  logic                  done_q;
  logic                  last_addr;
  logic                  slot_v;

  assign last_addr = (addr_q == SLOT_IDX_W'(SLOTS - 1));
  assign slot_v    = valid_i[chk_idx_q];
  assign re_o      = busy_q;
  assign raddr_o   = addr_q;

  always_comb begin
    busy_d     = busy_q;
    addr_d     = addr_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_seq_d  = hit_seq_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      addr_d = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else begin
      if (busy_q) begin
        busy_d = !last_addr;
        addr_d = addr_q + SLOT_IDX_W'(1);
      end
      if (chk_q) begin
        if (slot_v && rdata_i.client == caller_id_i && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = chk_idx_q;
          hit_seq_d = rdata_i.seq;
        end
        if (!slot_v && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = chk_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      addr_q <= '0;
      chk_q  <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
      chk_q  <= busy_q && !start_i;
      hit_q  <= hit_d;
      free_q <= free_d;
      done_q <= chk_q && !start_i && (chk_idx_q == SLOT_IDX_W'(SLOTS - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= addr_q;
    hit_idx_q  <= hit_idx_d;
    hit_seq_q  <= hit_seq_d;
    free_idx_q <= free_idx_d;
  end

  assign res_o.done     = done_q;
  assign res_o.hit      = hit_q;
  assign res_o.hit_idx  = hit_idx_q;
  assign res_o.hit_seq  = hit_seq_q;
  assign res_o.free     = free_q;
  assign res_o.free_idx = free_idx_q;

endmodule

@@ sv/duplicate_request_reply_cache.sv @@
// A well-formed request scans the whole slot table before its reply is loaded; a malformed one skips the scan.
// One transaction at a time: in_ready_o is high only in idle, so throughput is set by the sequential slot table scan
// through the single read port of the entry RAM and by out_ready_i back-pressure.
// Reset (rst_ni low, async): valid bits, victim pointer, counters, magic register cleared.
// Entry RAM is not cleared; entry data is used only behind a set valid bit.
`include "duplicate_request_reply_cache_assert.svh"
module duplicate_request_reply_cache import drrc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WORD_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_o
);

  state_e                state_q, state_d;
  logic [WORD_W-1:0]     magic_q;
  req_t                  req_q;
  logic [SLOTS-1:0]      valid_q;
  logic [SLOT_IDX_W-1:0] evict_q;
  logic [WORD_W-1:0]     handled_q;
  logic [WORD_W-1:0]     dup_q;
  action_e               action_q;
  logic [SLOT_IDX_W-1:0] slot_q;
  logic                  out_valid_q;
  rsp_t                  out_q;

  logic                  in_accept;
  logic                  req_bad;
  logic                  scan_start;
  logic                  decide;
  logic                  load_out;
  logic                  is_replay;
  logic                  is_stale;
  logic                  take_victim;
  logic [SLOT_IDX_W-1:0] exec_slot;
  logic                  ram_we;
  entry_t                ram_wdata;
  logic                  ram_re;
  logic [SLOT_IDX_W-1:0] ram_raddr;
  entry_t                ram_rdata;
  scan_res_t             scan_res;

  assign cfg_ready_o = 1'b1;
  assign req_bad     = !in_i.frame_ok || (in_i.magic_word != magic_q);
  assign in_accept   = in_valid_i && in_ready_o;

  assign is_replay   = scan_res.hit && (req_q.seq_number == scan_res.hit_seq);
  assign is_stale    = scan_res.hit && (req_q.seq_number < scan_res.hit_seq);
  assign take_victim = !scan_res.hit && !scan_res.free;
  assign exec_slot   = scan_res.hit  ? scan_res.hit_idx :
                       scan_res.free ? scan_res.free_idx : evict_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = req_bad ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    scan_start = 1'b0;
    decide     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        scan_start = in_valid_i && !req_bad;
      end
      ST_SCAN:   decide   = scan_res.done;
      ST_RESULT: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign ram_we          = decide && !is_replay && !is_stale;
  assign ram_wdata.client = req_q.caller_id;
  assign ram_wdata.seq    = req_q.seq_number;

  drrc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(exec_slot),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  drrc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .caller_id_i(req_q.caller_id),
    .valid_i    (valid_q),
    .rdata_i    (ram_rdata),
    .re_o       (ram_re),
    .raddr_o    (ram_raddr),
    .res_o      (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      magic_q     <= '0;
      valid_q     <= '0;
      evict_q     <= '0;
      handled_q   <= '0;
      dup_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        magic_q <= cfg_data_i;
      end
      if (ram_we) begin
        valid_q[exec_slot] <= 1'b1;
        if (handled_q != '1) begin
          handled_q <= handled_q + WORD_W'(1);
        end
        if (take_victim) begin
          evict_q <= (evict_q == SLOT_IDX_W'(SLOTS - 1)) ? '0 : evict_q + SLOT_IDX_W'(1);
        end
      end
      if (decide && is_replay && dup_q != '1) begin
        dup_q <= dup_q + WORD_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= in_i;
      action_q <= ACT_DROP_BAD;
      slot_q   <= '0;
    end
    if (decide) begin
      if (is_replay) begin
        action_q <= ACT_REPLAY;
        slot_q   <= scan_res.hit_idx;
      end else if (is_stale) begin
        action_q <= ACT_DROP_STALE;
        slot_q   <= '0;
      end else begin
        action_q <= ACT_EXECUTE;
        slot_q   <= exec_slot;
      end
    end
    if (load_out) begin
      out_q.action          <= action_q;
      out_q.slot_index      <= SLOT_FIELD_W'(slot_q);
      out_q.handled_count   <= handled_q;
      out_q.duplicate_count <= dup_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `DRRC_ASSERT_NOW(a_done_in_scan, scan_res.done, state_q == ST_SCAN)
  `DRRC_ASSERT_NEXT(a_write_sets_valid, ram_we, valid_q[$past(exec_slot)])
  `DRRC_ASSERT_NOW(a_drop_slot_zero,
    out_valid_o && (out_o.action == ACT_DROP_BAD || out_o.action == ACT_DROP_STALE),
    out_o.slot_index == '0)
  `DRRC_ASSERT_NEXT(a_counts_monotonic, 1'b1,
    handled_q >= $past(handled_q) && dup_q >= $past(dup_q))

endmodule

@@ tb/drrc_tb_pkg.sv @@
// Scoreboard class with the reply cache predictor and the queue of expected replies.
`timescale 1ns / 1ps
package drrc_tb_pkg;
  import drrc_pkg::*;

  class reply_cache_scoreboard;
    bit [WORD_W-1:0] magic;
    bit              slot_used [SLOTS];
    bit [WORD_W-1:0] slot_client [SLOTS];
    bit [WORD_W-1:0] slot_seq [SLOTS];
    int unsigned     victim;
    bit [WORD_W-1:0] handled;
    bit [WORD_W-1:0] dups;
    rsp_t            expected_replies [$];
    int unsigned     errors;

    function new();
      magic   = '0;
      victim  = 0;
      handled = '0;
      dups    = '0;
      errors  = 0;
      foreach (slot_used[i]) begin
        slot_used[i]   = 1'b0;
        slot_client[i] = '0;
        slot_seq[i]    = '0;
      end
    endfunction

    function void set_magic(bit [WORD_W-1:0] value);
      magic = value;
    endfunction

    function bit [WORD_W-1:0] sat_inc(bit [WORD_W-1:0] value);
      return (value == '1) ? value : value + 1;
    endfunction

    function void note_request(req_t req);
      rsp_t exp_rsp;
      int   hit;
      exp_rsp            = '0;
      exp_rsp.slot_index = '0;
      if (!req.frame_ok || req.magic_word != magic) begin
        exp_rsp.action = ACT_DROP_BAD;
      end else begin
        hit = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && slot_used[i] && slot_client[i] == req.caller_id) hit = i;
        end
        if (hit >= 0 && slot_seq[hit] == req.seq_number) begin
          exp_rsp.action     = ACT_REPLAY;
          exp_rsp.slot_index = SLOT_FIELD_W'(hit);
          dups               = sat_inc(dups);
        end else if (hit >= 0 && req.seq_number < slot_seq[hit]) begin
          exp_rsp.action = ACT_DROP_STALE;
        end else begin
          if (hit < 0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (hit < 0 && !slot_used[i]) hit = i;
            end
            if (hit < 0) begin
              hit    = victim;
              victim = (victim + 1) % SLOTS;
            end
          end
          slot_used[hit]     = 1'b1;
          slot_client[hit]   = req.caller_id;
          slot_seq[hit]      = req.seq_number;
          exp_rsp.action     = ACT_EXECUTE;
          exp_rsp.slot_index = SLOT_FIELD_W'(hit);
          handled            = sat_inc(handled);
        end
      end
      exp_rsp.handled_count   = handled;
      exp_rsp.duplicate_count = dups;
      expected_replies.push_back(exp_rsp);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      errors++;
    endtask

    task check_reply(rsp_t got);
      rsp_t exp_rsp;
      if (expected_replies.size() == 0) begin
        report("reply with no request pending");
      end else begin
        exp_rsp = expected_replies.pop_front();
        if (got.action !== exp_rsp.action)
          report($sformatf("action got %0d exp %0d", got.action, exp_rsp.action));
        if (got.slot_index !== exp_rsp.slot_index)
          report($sformatf("slot_index got %0d exp %0d", got.slot_index,
                           exp_rsp.slot_index));
        if (got.handled_count !== exp_rsp.handled_count)
          report($sformatf("handled_count got %0d exp %0d", got.handled_count,
                           exp_rsp.handled_count));
        if (got.duplicate_count !== exp_rsp.duplicate_count)
          report($sformatf("duplicate_count got %0d exp %0d", got.duplicate_count,
                           exp_rsp.duplicate_count));
      end
    endtask
  endclass

endpackage

@@ tb/tb_top.sv @@
// Top-level testbench of the duplicate request reply cache.
`timescale 1ns / 1ps
module tb_top import drrc_pkg::*, drrc_tb_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned POOL_MAX    = 96;
  localparam int unsigned PHASE_ITEMS = 325;
  localparam int unsigned END_SETTLE  = 70;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [WORD_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  req_t              in_i;
  logic              out_valid_o;
  logic              out_ready_i;
  rsp_t              out_o;

  reply_cache_scoreboard sb;

  bit [WORD_W-1:0] pool_id [POOL_MAX];
  bit [WORD_W-1:0] pool_seq [POOL_MAX];
  int unsigned     sent_count;
  bit              sender_steady;
  int unsigned     cycle_count;

  duplicate_request_reply_cache DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("duplicate_request_reply_cache test failed");
    $finish;
  end

  function automatic req_t mk_req(bit ok, bit [WORD_W-1:0] magic, bit [WORD_W-1:0] id,
                                  bit [WORD_W-1:0] seq);
    req_t req;
    req.frame_ok   = ok;
    req.magic_word = magic;
    req.caller_id  = id;
    req.seq_number = seq;
    return req;
  endfunction

  task automatic send_req(req_t req);
    int unsigned gap;
    if (sent_count % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
    sent_count++;
    gap = sender_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
  endtask

  task automatic write_magic(bit [WORD_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_magic(value);
  endtask

  task automatic wait_idle(int unsigned settle);
    in_valid_i <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // mostly well-formed traffic from a client pool; replays, stale and new calls
  task automatic random_phase(bit [WORD_W-1:0] magic, int unsigned pool_size);
    req_t        req;
    int unsigned c;
    int unsigned k;
    int unsigned m;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      c = $urandom_range(0, pool_size - 1);
      k = $urandom_range(0, 99);
      m = $urandom_range(0, 99);
      req.frame_ok   = (k >= 4);
      req.magic_word = (k >= 4 && k < 10) ? $urandom() : magic;
      req.caller_id  = (k >= 95) ? $urandom() : pool_id[c];
      if (m < 30)
        req.seq_number = pool_seq[c];
      else if (m < 45)
        req.seq_number = pool_seq[c] - $urandom_range(1, 200);
      else if (m < 90)
        req.seq_number = pool_seq[c] + $urandom_range(1, 64);
      else
        req.seq_number = $urandom();
      if (req.frame_ok && req.magic_word == magic && k < 95 && m >= 45)
        pool_seq[c] = req.seq_number;
      send_req(req);
    end
  endtask

  initial begin
    bit receiver_steady;
    int unsigned n;
    int unsigned taken;
    out_ready_i <= 1'b0;
    taken = 0;
    receiver_steady = 1'b0;
    wait (rst_ni);
    forever begin
      if (taken % 40 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      taken++;
      n = receiver_steady ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_reply(out_o);
    end
  end

  initial begin
    sb            = new();
    sent_count    = 0;
    sender_steady = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_i        <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    pool_id[0] = '0;
    pool_id[1] = '1;
    for (int i = 2; i < POOL_MAX; i++) pool_id[i] = $urandom();
    for (int i = 0; i < POOL_MAX; i++) pool_seq[i] = $urandom();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset magic is zero
    send_req(mk_req(1'b0, 32'h0, 32'h0, 32'h0));
    send_req(mk_req(1'b1, 32'h0, 32'h0, 32'h0));
    send_req(mk_req(1'b1, 32'h0, 32'h0, 32'h0));
    send_req(mk_req(1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(mk_req(1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0));
    send_req(mk_req(1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_req(mk_req(1'b1, 32'h0, 32'h0, 32'h5));
    send_req(mk_req(1'b1, 32'h0, 32'h0, 32'h0));
    send_req(mk_req(1'b1, 32'h0, 32'h0, 32'h5));
    wait_idle(4);
    write_magic(32'hFFFF_FFFF);
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'h0, 32'h5));
    send_req(mk_req(1'b1, 32'h0, 32'h0, 32'h5));
    send_req(mk_req(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h5));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 32'h7FFF_FFFF));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000));
    send_req(mk_req(1'b1, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5B));
    wait_idle(4);

    begin
      bit [WORD_W-1:0] magic_plan [6];
      int unsigned     pool_plan [6];
      magic_plan = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};
      pool_plan  = '{6, 40, 96, 96, 20, 70};
      magic_plan[0] = $urandom();
      magic_plan[3] = $urandom();
      magic_plan[4] = $urandom();
      for (int p = 0; p < 6; p++) begin
        write_magic(magic_plan[p]);
        random_phase(magic_plan[p], pool_plan[p]);
        wait_idle(4);
      end
    end

    wait_idle(END_SETTLE);
    if (sb.expected_replies.size() != 0) sb.report("requests left without a reply");
    if (sb.errors == 0) begin
      $display("duplicate_request_reply_cache test passed");
    end else begin
      $display("duplicate_request_reply_cache test failed");
    end
    $finish;
  end

endmodule
